// File: sv/ucer_pkg.sv
// ----------------------------------------------------------------------------
// ucer_pkg
// Types, codes and descriptor table of the endpoint-0 control responder.
// ----------------------------------------------------------------------------
package ucer_pkg;

  // Token-done event kinds
  typedef enum logic [1:0] {
    CMD_BUS_RESET = 2'd0,
    CMD_SETUP     = 2'd1,
    CMD_IN        = 2'd2,
    CMD_OUT       = 2'd3
  } cmd_e;

  // Result actions
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_QUEUE = 2'd1,
    ACT_STALL = 2'd2
  } action_e;

  // Request codes (request number * 256 + request type)
  localparam logic [15:0] REQ_SET_ADDRESS  = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG   = 16'h0900;
  localparam logic [15:0] REQ_GET_DESC_DEV = 16'h0680;
  localparam logic [15:0] REQ_GET_DESC_IF  = 16'h0681;

  localparam int unsigned TABLE_SIZE = 5;

  // One input item
  typedef struct packed {
    cmd_e        cmd;
    logic        rx_bank;
    logic [15:0] request_code;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } item_t;

  // One result item
  typedef struct packed {
    action_e     action;
    logic        rearm_rx;
    logic        rearm_bank;
    logic        tx_bank_used;
    logic        toggle_used;
    logic [2:0]  desc_index;
    logic [7:0]  byte_offset;
    logic [6:0]  byte_count;
    logic        address_valid;
    logic [6:0]  device_address;
    logic        last;
  } res_t;

  // Result queue status
  typedef struct packed {
    logic [2:0] count;
    logic       room2;
  } fifo_stat_t;

  // Descriptor key: type * 256 + index
  function automatic logic [15:0] desc_key_value(input logic [2:0] idx);
    logic [15:0] v;
    case (idx)
      3'd0:    v = 16'h0100;
      3'd1:    v = 16'h0200;
      3'd2:    v = 16'h0300;
      3'd3:    v = 16'h0301;
      3'd4:    v = 16'h0302;
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

  // Language id expected with each descriptor
  function automatic logic [15:0] desc_key_index(input logic [2:0] idx);
    logic [15:0] v;
    case (idx)
      3'd3, 3'd4: v = 16'h0409;
      default:    v = 16'h0000;
    endcase
    return v;
  endfunction

  // Descriptor length in bytes
  function automatic logic [7:0] desc_length(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd18;
      3'd1:    v = 8'd25;
      3'd2:    v = 8'd4;
      3'd3:    v = 8'd28;
      3'd4:    v = 8'd22;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/ucer_core.sv
// ----------------------------------------------------------------------------
// ucer_core
// Endpoint state and single-pass event decode: produces up to two results.
// ----------------------------------------------------------------------------
module ucer_core #(
  parameter int unsigned MAX_PACKET = 64,
  parameter int unsigned DESC_COUNT = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  ucer_pkg::item_t item_i,
  output ucer_pkg::res_t  res0_o,
  output ucer_pkg::res_t  res1_o,
  output logic [1:0]     nres_o
);
  import ucer_pkg::*;

  localparam logic [7:0] MaxP = 8'(MAX_PACKET);

  logic       tx_bank_q, tx_bank_d;
  logic       toggle_q, toggle_d;
  logic       pend_valid_q, pend_valid_d;
  logic [2:0] pend_desc_q, pend_desc_d;
  logic [7:0] pend_off_q, pend_off_d;
  logic [7:0] pend_rem_q, pend_rem_d;
  logic [15:0] saved_req_q, saved_req_d;
  logic [15:0] saved_val_q, saved_val_d;

  // Descriptor lookup over the first DESC_COUNT table entries
  logic       found;
  logic [2:0] found_idx;
  always_comb begin
    found     = 1'b0;
    found_idx = 3'd0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < DESC_COUNT && desc_key_value(3'(i)) == item_i.setup_value &&
          desc_key_index(3'(i)) == item_i.setup_index) begin
        found     = 1'b1;
        found_idx = 3'(i);
      end
    end
  end

  // Chunk sizes of a get-descriptor response
  logic [7:0] dlen, len0, size1, len1, size2, len2, off2;
  logic       single, keep_pend;
  always_comb begin
    dlen      = desc_length(found_idx);
    len0      = (item_i.setup_length < {8'd0, dlen}) ? item_i.setup_length[7:0] : dlen;
    size1     = (len0 > MaxP) ? MaxP : len0;
    len1      = len0 - size1;
    size2     = (len1 > MaxP) ? MaxP : len1;
    len2      = len1 - size2;
    off2      = size1 + size2;
    single    = (len1 == 8'd0) && (size1 < MaxP);
    keep_pend = !((len2 == 8'd0) && (size2 < MaxP));
  end

  // In-event chunk
  logic [7:0] in_size, in_rem;
  always_comb begin
    in_size = (pend_rem_q > MaxP) ? MaxP : pend_rem_q;
    in_rem  = pend_rem_q - in_size;
  end

  // Event decode and next state
  always_comb begin
    res0_o       = '0;
    res1_o       = '0;
    nres_o       = 2'd0;
    tx_bank_d    = tx_bank_q;
    toggle_d     = toggle_q;
    pend_valid_d = pend_valid_q;
    pend_desc_d  = pend_desc_q;
    pend_off_d   = pend_off_q;
    pend_rem_d   = pend_rem_q;
    saved_req_d  = saved_req_q;
    saved_val_d  = saved_val_q;
    case (item_i.cmd)
      CMD_BUS_RESET: begin
        tx_bank_d = 1'b0;
      end
      CMD_SETUP: begin
        saved_req_d       = item_i.request_code;
        saved_val_d       = item_i.setup_value;
        pend_valid_d      = 1'b0;
        toggle_d          = 1'b1;
        res0_o.rearm_rx   = 1'b1;
        res0_o.rearm_bank = item_i.rx_bank;
        res0_o.last       = 1'b1;
        nres_o            = 2'd1;
        if (item_i.request_code == REQ_SET_ADDRESS ||
            item_i.request_code == REQ_SET_CONFIG) begin
          // zero-length status packet
          res0_o.action       = ACT_QUEUE;
          res0_o.tx_bank_used = tx_bank_q;
          res0_o.toggle_used  = 1'b1;
          tx_bank_d           = ~tx_bank_q;
          toggle_d            = 1'b0;
        end else if ((item_i.request_code == REQ_GET_DESC_DEV ||
                      item_i.request_code == REQ_GET_DESC_IF) && found) begin
          res0_o.action       = ACT_QUEUE;
          res0_o.tx_bank_used = tx_bank_q;
          res0_o.toggle_used  = 1'b1;
          res0_o.desc_index   = found_idx;
          res0_o.byte_offset  = 8'd0;
          res0_o.byte_count   = size1[6:0];
          if (single) begin
            tx_bank_d = ~tx_bank_q;
            toggle_d  = 1'b0;
          end else begin
            // second chunk on the other bank with DATA0
            res0_o.last         = 1'b0;
            res1_o.action       = ACT_QUEUE;
            res1_o.tx_bank_used = ~tx_bank_q;
            res1_o.toggle_used  = 1'b0;
            res1_o.desc_index   = found_idx;
            res1_o.byte_offset  = size1;
            res1_o.byte_count   = size2[6:0];
            res1_o.last         = 1'b1;
            nres_o              = 2'd2;
            if (keep_pend) begin
              pend_valid_d = 1'b1;
              pend_desc_d  = found_idx;
              pend_off_d   = off2;
              pend_rem_d   = len2;
            end
          end
        end else begin
          res0_o.action = ACT_STALL;
        end
      end
      CMD_IN: begin
        if (pend_valid_q) begin
          res0_o.action       = ACT_QUEUE;
          res0_o.tx_bank_used = tx_bank_q;
          res0_o.toggle_used  = toggle_q;
          res0_o.desc_index   = pend_desc_q;
          res0_o.byte_offset  = pend_off_q;
          res0_o.byte_count   = in_size[6:0];
          tx_bank_d           = ~tx_bank_q;
          toggle_d            = ~toggle_q;
          pend_off_d          = pend_off_q + in_size;
          pend_rem_d          = in_rem;
          if (!(in_rem != 8'd0 || in_size == MaxP)) pend_valid_d = 1'b0;
          nres_o      = 2'd1;
          res0_o.last = 1'b1;
        end
        if (saved_req_q == REQ_SET_ADDRESS) begin
          res0_o.address_valid  = 1'b1;
          res0_o.device_address = saved_val_q[6:0];
          nres_o                = 2'd1;
          res0_o.last           = 1'b1;
        end
      end
      CMD_OUT: begin
        res0_o.rearm_rx   = 1'b1;
        res0_o.rearm_bank = item_i.rx_bank;
        res0_o.last       = 1'b1;
        nres_o            = 2'd1;
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_bank_q    <= 1'b0;
      toggle_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_desc_q  <= 3'd0;
      pend_off_q   <= 8'd0;
      pend_rem_q   <= 8'd0;
      saved_req_q  <= 16'd0;
      saved_val_q  <= 16'd0;
    end else if (step_i) begin
      tx_bank_q    <= tx_bank_d;
      toggle_q     <= toggle_d;
      pend_valid_q <= pend_valid_d;
      pend_desc_q  <= pend_desc_d;
      pend_off_q   <= pend_off_d;
      pend_rem_q   <= pend_rem_d;
      saved_req_q  <= saved_req_d;
      saved_val_q  <= saved_val_d;
    end
  end

endmodule

// File: sv/ucer_fifo.sv
// ----------------------------------------------------------------------------
// ucer_fifo
// Four-entry result queue: takes up to two results in, hands one out a cycle while popped.
// ----------------------------------------------------------------------------
module ucer_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  ucer_pkg::res_t     push0_i,
  input  ucer_pkg::res_t     push1_i,
  input  logic               pop_i,
  output ucer_pkg::res_t     head_o,
  output logic               valid_o,
  output ucer_pkg::fifo_stat_t stat_o
);
  import ucer_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] count_q;
  logic       do_pop;

  assign do_pop       = pop_i && (count_q != 3'd0);
  assign head_o       = mem_q[rptr_q];
  assign valid_o      = (count_q != 3'd0);
  assign stat_o.count = count_q;
  assign stat_o.room2 = (count_q <= 3'd2);

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wptr_q] <= push0_i;
    if (push_n_i == 2'd2) mem_q[wptr_q + 2'd1] <= push1_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 2'd0;
      rptr_q  <= 2'd0;
      count_q <= 3'd0;
    end else begin
      wptr_q  <= wptr_q + push_n_i;
      if (do_pop) rptr_q <= rptr_q + 2'd1;
      count_q <= count_q + {1'b0, push_n_i} - {2'd0, do_pop};
    end
  end

endmodule

// File: sv/usb_control_endpoint_responder.sv
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder
// Endpoint-0 control responder: token-done events in, controller actions out.
// ----------------------------------------------------------------------------
// Path: input register, then decode into the result queue; the first result
//   is presented from the result queue.
// Throughput: one event per cycle while the result queue has room for two results;
//   a two-packet get-descriptor response leaves one result at a time by the output port.
// Reset: asynchronous, active low; clears endpoint state and empties queues.
module usb_control_endpoint_responder #(
  parameter int unsigned MAX_PACKET = 64,
  parameter int unsigned DESC_COUNT = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_bank[0], request_code[16:1], setup_value[32:17], setup_index[48:33],
  // setup_length[64:49], zero fill above
  input  logic [71:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rearm_rx[0], rearm_bank[1], tx_bank_used[2], toggle_used[3],
  // desc_index[6:4], byte_offset[14:7], byte_count[21:15], address_valid[22],
  // device_address[29:23], zero fill above
  output logic [31:0] m_axis_tdata,
  // action[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import ucer_pkg::*;

  item_t      item_q;
  logic       item_valid_q;
  logic       step;
  res_t       res0, res1, head;
  logic [1:0] nres;
  fifo_stat_t stat;

  // Input register
  assign step          = item_valid_q && stat.room2;
  assign s_axis_tready = !item_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.cmd          <= cmd_e'(s_axis_tuser);
      item_q.rx_bank      <= s_axis_tdata[0];
      item_q.request_code <= s_axis_tdata[16:1];
      item_q.setup_value  <= s_axis_tdata[32:17];
      item_q.setup_index  <= s_axis_tdata[48:33];
      item_q.setup_length <= s_axis_tdata[64:49];
    end
  end

  // Decode and endpoint state
  ucer_core #(
    .MAX_PACKET(MAX_PACKET),
    .DESC_COUNT(DESC_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .res0_o (res0),
    .res1_o (res1),
    .nres_o (nres)
  );

  // Result queue
  ucer_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (step ? nres : 2'd0),
    .push0_i  (res0),
    .push1_i  (res1),
    .pop_i    (m_axis_tready),
    .head_o   (head),
    .valid_o  (m_axis_tvalid),
    .stat_o   (stat)
  );

  // Output packing
  assign m_axis_tuser = head.action;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {2'b00, head.device_address, head.address_valid, head.byte_count,
                         head.byte_offset, head.desc_index, head.toggle_used,
                         head.tx_bank_used, head.rearm_bank, head.rearm_rx};

  // Checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= 3'd4)
    else $error("result queue overflow");

  a_stall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && head.action == ACT_STALL) |-> head.last)
    else $error("stall result not final");

  a_rearm_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !head.rearm_rx) |-> !head.rearm_bank)
    else $error("rearm bank set without rearm");

  a_two_only_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && nres == 2'd2) |-> (item_q.cmd == CMD_SETUP && !res0.last && res1.last))
    else $error("bad two-result response");

endmodule

// File: tb/tb_usb_control_endpoint_responder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_control_endpoint_responder
// Self-checking bench for the endpoint-0 control responder. Token-done events
// go in on the slave stream with random gaps. The controller actions that come
// back are checked field by field against an in-bench model of the endpoint
// state: bank and toggle, pending transfer and the stored setup request.
// ----------------------------------------------------------------------------
import ucer_pkg::*;

localparam int unsigned EP0_MAX_PACKET = 64;
localparam int unsigned EP0_DESC_COUNT = 5;
localparam logic [15:0] LANG_US_ENGLISH = 16'h0409;

// Endpoint model plus the queue of controller actions still owed by the block
class ep0_action_checker;
  // descriptor table: key word, language id, length
  bit [15:0] key_value [5] = '{16'h0100, 16'h0200, 16'h0300, 16'h0301, 16'h0302};
  bit [15:0] key_lang  [5] = '{16'h0000, 16'h0000, 16'h0000, LANG_US_ENGLISH,
                               LANG_US_ENGLISH};
  bit [7:0]  desc_len  [5] = '{8'd18, 8'd25, 8'd4, 8'd28, 8'd22};

  // endpoint state
  bit        tx_bank;
  bit        data_toggle;
  bit        pend_valid;
  bit [2:0]  pend_desc;
  bit [7:0]  pend_offset;
  bit [7:0]  pend_remaining;
  bit [15:0] saved_request;
  bit [15:0] saved_value;

  res_t expected_actions[$];

  int unsigned tokens_seen, results_seen, mismatches;
  int unsigned stall_count, status_count, data_packets, address_writes;

  function new();
    tx_bank = 0;
    data_toggle = 0;
    pend_valid = 0;
    pend_desc = '0;
    pend_offset = '0;
    pend_remaining = '0;
    saved_request = '0;
    saved_value = '0;
  endfunction

  // fill in a transmit packet and advance bank and toggle
  function void load_packet(inout res_t r, input int unsigned d, input int unsigned off,
                            input int unsigned cnt);
    r.action       = ACT_QUEUE;
    r.tx_bank_used = tx_bank;
    r.toggle_used  = data_toggle;
    r.desc_index   = 3'(d);
    r.byte_offset  = 8'(off);
    r.byte_count   = 7'(cnt);
    tx_bank     = ~tx_bank;
    data_toggle = ~data_toggle;
    if (cnt == 0) status_count++;
    else data_packets++;
  endfunction

  function int unsigned chunk_of(int unsigned len);
    return (len > EP0_MAX_PACKET) ? EP0_MAX_PACKET : len;
  endfunction

  // predict the actions caused by one accepted token event
  function void note_token(item_t it);
    res_t        r0, r1;
    int unsigned len, size, off, hit;
    bit          found;
    tokens_seen++;
    r0 = '0;
    r1 = '0;
    case (it.cmd)
      CMD_BUS_RESET: begin
        tx_bank = 0;
      end
      CMD_SETUP: begin
        saved_request = it.request_code;
        saved_value   = it.setup_value;
        pend_valid    = 0;
        data_toggle   = 1;
        r0.rearm_rx   = 1'b1;
        r0.rearm_bank = it.rx_bank;
        r0.last       = 1'b1;
        found = 0;
        hit   = 0;
        if (it.request_code == REQ_SET_ADDRESS || it.request_code == REQ_SET_CONFIG) begin
          load_packet(r0, 0, 0, 0);
          expected_actions.push_back(r0);
        end else begin
          if (it.request_code == REQ_GET_DESC_DEV || it.request_code == REQ_GET_DESC_IF) begin
            for (int i = 0; i < EP0_DESC_COUNT && i < 5; i++) begin
              if (!found && key_value[i] == it.setup_value && key_lang[i] == it.setup_index) begin
                found = 1;
                hit   = i;
              end
            end
          end
          if (!found) begin
            r0.action = ACT_STALL;
            stall_count++;
            expected_actions.push_back(r0);
          end else begin
            len = desc_len[hit];
            if (len > it.setup_length) len = it.setup_length;
            size = chunk_of(len);
            load_packet(r0, hit, 0, size);
            len -= size;
            off  = size;
            if (len == 0 && size < EP0_MAX_PACKET) begin
              expected_actions.push_back(r0);
            end else begin
              // second chunk goes out at once, the rest waits for in tokens
              r0.last = 1'b0;
              expected_actions.push_back(r0);
              size = chunk_of(len);
              load_packet(r1, hit, off, size);
              len -= size;
              off += size;
              if (!(len == 0 && size < EP0_MAX_PACKET)) begin
                pend_valid     = 1;
                pend_desc      = 3'(hit);
                pend_offset    = 8'(off);
                pend_remaining = 8'(len);
              end
              r1.last = 1'b1;
              expected_actions.push_back(r1);
            end
          end
        end
      end
      CMD_IN: begin
        found = 0;
        if (pend_valid) begin
          size = chunk_of(pend_remaining);
          load_packet(r0, pend_desc, pend_offset, size);
          pend_offset    = 8'(pend_offset + size);
          pend_remaining = 8'(pend_remaining - size);
          if (!(pend_remaining > 0 || size == EP0_MAX_PACKET)) pend_valid = 0;
          found = 1;
        end
        // a stored set-address is applied on every in token
        if (saved_request == REQ_SET_ADDRESS) begin
          r0.address_valid  = 1'b1;
          r0.device_address = saved_value[6:0];
          address_writes++;
          found = 1;
        end
        if (found) begin
          r0.last = 1'b1;
          expected_actions.push_back(r0);
        end
      end
      default: begin
        r0.rearm_rx   = 1'b1;
        r0.rearm_bank = it.rx_bank;
        r0.last       = 1'b1;
        expected_actions.push_back(r0);
      end
    endcase
  endfunction

  function void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // compare one result transfer with the oldest expected action
  function void check_action(res_t got);
    res_t  want;
    string diffs;
    results_seen++;
    if (expected_actions.size() == 0) begin
      note_mismatch($sformatf("result %0d with nothing expected: %p", results_seen, got));
      return;
    end
    want  = expected_actions.pop_front();
    diffs = "";
    if (got.action !== want.action)                 diffs = {diffs, " action"};
    if (got.rearm_rx !== want.rearm_rx)             diffs = {diffs, " rearm_rx"};
    if (got.rearm_bank !== want.rearm_bank)         diffs = {diffs, " rearm_bank"};
    if (got.tx_bank_used !== want.tx_bank_used)     diffs = {diffs, " tx_bank_used"};
    if (got.toggle_used !== want.toggle_used)       diffs = {diffs, " toggle_used"};
    if (got.desc_index !== want.desc_index)         diffs = {diffs, " desc_index"};
    if (got.byte_offset !== want.byte_offset)       diffs = {diffs, " byte_offset"};
    if (got.byte_count !== want.byte_count)         diffs = {diffs, " byte_count"};
    if (got.address_valid !== want.address_valid)   diffs = {diffs, " address_valid"};
    if (got.device_address !== want.device_address) diffs = {diffs, " device_address"};
    if (got.last !== want.last)                     diffs = {diffs, " last"};
    if (diffs != "")
      note_mismatch($sformatf("result %0d differs in%s: expected %p, got %p",
                              results_seen, diffs, want, got));
  endfunction
endclass

module tb_usb_control_endpoint_responder;

  localparam int unsigned RANDOM_TOKENS = 1700;
  localparam int unsigned HOLD_AT_RESULT = 400;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  ep0_action_checker sb;
  bit                no_gaps;
  int unsigned       hold_left, calm_left, stall_left;

  usb_control_endpoint_responder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // hard stop for a hung run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic item_t setup_token(logic [15:0] rc, logic [15:0] sv, logic [15:0] si,
                                        logic [15:0] sl);
    item_t it;
    it.cmd          = CMD_SETUP;
    it.rx_bank      = 1'($urandom);
    it.request_code = rc;
    it.setup_value  = sv;
    it.setup_index  = si;
    it.setup_length = sl;
    return it;
  endfunction

  // token of the given kind with every other field random
  function automatic item_t noise_token(cmd_e c);
    item_t it;
    it.cmd          = c;
    it.rx_bank      = 1'($urandom);
    it.request_code = 16'($urandom);
    it.setup_value  = 16'($urandom);
    it.setup_index  = 16'($urandom);
    it.setup_length = 16'($urandom);
    return it;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one token after a random gap, return once it is transferred
  task automatic send_token(input item_t it);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.setup_length, it.setup_index, it.setup_value,
                      it.request_code, it.rx_bank};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_token(it);
  endtask

  // result side: check each transfer, then pick next cycle's ready
  always @(posedge clk_i) begin : result_side
    res_t        got;
    bit          rdy;
    int unsigned r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action         = action_e'(m_axis_tuser);
      got.rearm_rx       = m_axis_tdata[0];
      got.rearm_bank     = m_axis_tdata[1];
      got.tx_bank_used   = m_axis_tdata[2];
      got.toggle_used    = m_axis_tdata[3];
      got.desc_index     = m_axis_tdata[6:4];
      got.byte_offset    = m_axis_tdata[14:7];
      got.byte_count     = m_axis_tdata[21:15];
      got.address_valid  = m_axis_tdata[22];
      got.device_address = m_axis_tdata[29:23];
      got.last           = m_axis_tlast;
      sb.check_action(got);
      // one long hold-off so the block backs up into its input
      if (sb.results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
    end
    rdy = 1'b1;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (calm_left != 0) begin
      calm_left--;
    end else if (stall_left != 0) begin
      stall_left--;
      rdy = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        calm_left = $urandom_range(50, 150);
      end else if (r >= 70) begin
        rdy = 1'b0;
        stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
    m_axis_tready <= rdy;
  end

  initial begin : stimulus
    int unsigned n, k, len;
    logic [15:0] rc;
    sb = new();
    no_gaps = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_BUS_RESET;
    m_axis_tready <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every event kind, each request, each descriptor, edge lengths
    send_token(setup_token(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_token(noise_token(CMD_BUS_RESET));
    send_token(noise_token(CMD_IN));            // nothing pending, no address
    send_token(setup_token(REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000));
    send_token(noise_token(CMD_IN));            // address only, no packet
    send_token(setup_token(REQ_SET_CONFIG, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_token(noise_token(CMD_IN));
    send_token(setup_token(REQ_GET_DESC_DEV, 16'h0100, 16'h0000, 16'hFFFF));
    send_token(noise_token(CMD_IN));
    send_token(setup_token(REQ_GET_DESC_IF, 16'h0200, 16'h0000, 16'h0000));
    send_token(setup_token(REQ_GET_DESC_DEV, 16'h0300, 16'h0000, 16'h0001));
    send_token(setup_token(REQ_GET_DESC_DEV, 16'h0301, LANG_US_ENGLISH, 16'd64));
    send_token(setup_token(REQ_GET_DESC_IF, 16'h0302, LANG_US_ENGLISH, 16'd21));
    send_token(setup_token(REQ_GET_DESC_DEV, 16'h0301, 16'h0000, 16'd64));
    send_token(setup_token(REQ_GET_DESC_DEV, 16'h0100, LANG_US_ENGLISH, 16'd8));
    send_token(setup_token(16'h0682, 16'h0100, 16'h0000, 16'd8));
    send_token(setup_token(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_token(noise_token(CMD_OUT));
    send_token(noise_token(CMD_OUT));
    send_token(setup_token(REQ_SET_ADDRESS, 16'h0080, 16'h0000, 16'h0000));
    send_token(noise_token(CMD_BUS_RESET));
    send_token(noise_token(CMD_IN));
    send_token(setup_token(REQ_SET_ADDRESS, 16'h0005, 16'h0000, 16'h0000));
    send_token(noise_token(CMD_IN));
    send_token(noise_token(CMD_IN));

    // random control transfers with noise and broken requests mixed in
    while (sb.tokens_seen < RANDOM_TOKENS) begin
      n = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 4);
      if (n < 40) begin
        rc = $urandom_range(0, 1) ? REQ_GET_DESC_IF : REQ_GET_DESC_DEV;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(0, 40);
          6, 7:             len = sb.desc_len[k] + $urandom_range(0, 2) - 1;
          default:          len = $urandom_range(0, 65535);
        endcase
        send_token(setup_token(rc, sb.key_value[k], sb.key_lang[k], 16'(len)));
        repeat ($urandom_range(0, 2)) send_token(noise_token(CMD_IN));
        send_token(noise_token(CMD_OUT));
      end else if (n < 55) begin
        send_token(setup_token(REQ_SET_ADDRESS, 16'($urandom), 16'($urandom), 16'($urandom)));
        repeat ($urandom_range(1, 3)) send_token(noise_token(CMD_IN));
      end else if (n < 65) begin
        send_token(setup_token(REQ_SET_CONFIG, 16'($urandom), 16'($urandom), 16'($urandom)));
        send_token(noise_token(CMD_IN));
        send_token(noise_token(CMD_OUT));
      end else if (n < 72) begin
        send_token(noise_token(CMD_BUS_RESET));
        send_token(noise_token(CMD_IN));
      end else if (n < 85) begin
        // right request, key or language scrambled
        rc = $urandom_range(0, 1) ? REQ_GET_DESC_IF : REQ_GET_DESC_DEV;
        if ($urandom_range(0, 1))
          send_token(setup_token(rc, sb.key_value[k], 16'($urandom), 16'($urandom)));
        else
          send_token(setup_token(rc, 16'($urandom), sb.key_lang[k], 16'($urandom)));
        send_token(noise_token(CMD_IN));
      end else begin
        send_token(noise_token(cmd_e'($urandom_range(0, 3))));
      end
    end

    // drain
    s_axis_tvalid <= 1'b0;
    while (sb.expected_actions.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Covered %0d token events and %0d result transfers.",
             sb.tokens_seen, sb.results_seen);
    $display("Status packets %0d, descriptor packets %0d, stalls %0d, address writes %0d.",
             sb.status_count, sb.data_packets, sb.stall_count, sb.address_writes);
    if (sb.mismatches == 0 && sb.expected_actions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.expected_actions.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
